// ----- rtl/core/hls_pkg.sv -----
// ============================================================================
// hls_pkg
// Shared types and constants for the heartbeat link supervisor: beat
// layouts of both channels, the configuration set, codes and reset values.
// ============================================================================
package hls_pkg;

    // Configuration port geometry.
    localparam int unsigned CFG_DATA_W  = 8;
    localparam int unsigned CFG_INDEX_W = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_W-1:0] REG_HEARTBEAT_RELOAD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RETRY_WAIT       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_CLASS     = 2'd2;

    // Register reset values.
    localparam logic [7:0] RESET_HEARTBEAT_RELOAD = 8'd200;
    localparam logic [3:0] RESET_RETRY_WAIT       = 4'd6;
    localparam logic [7:0] RESET_DEVICE_CLASS     = 8'h06;

    // Function code of a heartbeat frame.
    localparam logic [7:0] HEARTBEAT_FUNCTION = 8'hB0;

    // Command codes of an input beat.
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_FRAME = 1'b1;

    // Link event codes.
    localparam logic [1:0] LINK_EV_NONE    = 2'd0;
    localparam logic [1:0] LINK_EV_ONLINE  = 2'd1;
    localparam logic [1:0] LINK_EV_OFFLINE = 2'd2;

    // Enable event codes.
    localparam logic [1:0] EN_EV_NONE     = 2'd0;
    localparam logic [1:0] EN_EV_ENABLED  = 2'd1;
    localparam logic [1:0] EN_EV_DISABLED = 2'd2;

    typedef struct packed {
        logic       cmd;
        logic [7:0] frame_class;
        logic [7:0] frame_type;
        logic [7:0] frame_number;
        logic [7:0] frame_function;
        logic [7:0] frame_byte0;
    } in_beat_t;

    typedef struct packed {
        logic       link_online;
        logic       device_enabled;
        logic [1:0] link_event;
        logic [1:0] enable_event;
        logic       send_enable;
        logic [7:0] target_type;
        logic [7:0] target_number;
    } out_beat_t;

    typedef struct packed {
        logic [7:0] heartbeat_reload;
        logic [3:0] retry_wait;
        logic [7:0] device_class;
    } cfg_t;

endpackage

// ----- rtl/core/heartbeat_link_supervisor.sv -----
// ============================================================================
// heartbeat_link_supervisor
// Watches a remote power module over a frame link: heartbeat watchdog, link
// online/offline tracking and an enable handshake with retry wait.
// ============================================================================
// Usage:
//   Input beats (in_valid/in_ready, in_data) are either a supervision tick
//   (cmd 0) or a received frame (cmd 1). Every input beat yields exactly one
//   output beat (out_valid/out_ready, out_data) carrying the link and enable
//   flags, the link and enable events, the send_enable request and the
//   captured device type and number to address an enable command to.
//   An accepted beat is loaded into the input register; when it fires, the
//   step result is written into the result register, which drives out_valid.
//   Throughput is one beat per cycle while the receiver does not stall, set
//   by the step between the input register and the result register.
//   When the receiver stalls, the result register holds its beat and the
//   input register fills; in_ready then drops until out_ready returns.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the
//   next clock edge and are meant to be issued while the block is idle.
//   Reset loads the register defaults (reload 200, retry wait 6, class 6),
//   preloads the watchdog and retry wait from them and empties the pipeline.
// ============================================================================
module heartbeat_link_supervisor (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  hls_pkg::in_beat_t                    in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output hls_pkg::out_beat_t                   out_data,
    input  logic                                 cfg_we,
    input  logic [hls_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [hls_pkg::CFG_DATA_W-1:0]       cfg_data
);

    hls_pkg::cfg_t      cfg_reg;
    logic               item_valid_reg;
    hls_pkg::in_beat_t  item_reg;
    logic               out_valid_reg;
    hls_pkg::out_beat_t out_data_reg;
    hls_pkg::out_beat_t step_res;
    logic               fire;

    // The stored beat advances whenever the result register is free or draining.
    assign fire     = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || fire;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.heartbeat_reload <= hls_pkg::RESET_HEARTBEAT_RELOAD;
            cfg_reg.retry_wait       <= hls_pkg::RESET_RETRY_WAIT;
            cfg_reg.device_class     <= hls_pkg::RESET_DEVICE_CLASS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hls_pkg::REG_HEARTBEAT_RELOAD: cfg_reg.heartbeat_reload <= cfg_data;
                hls_pkg::REG_RETRY_WAIT:       cfg_reg.retry_wait       <= cfg_data[3:0];
                hls_pkg::REG_DEVICE_CLASS:     cfg_reg.device_class     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
    end

    // Step logic and supervision state.
    hls_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .cfg   (cfg_reg),
        .res   (step_res)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= step_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    // A stored beat is never dropped: no new beat enters while it is stalled.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && !fire |-> !in_ready)
        else $error("input register overwritten while stalled");

    // A stalled result stays valid.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg)
        else $error("result dropped while the receiver stalls");

    // Every accepted beat is in the input register in the next cycle
    // when the output side is free.
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && out_ready |=> item_valid_reg)
        else $error("accepted beat lost");
`endif

endmodule

// ----- rtl/core/hls_engine.sv -----
// ============================================================================
// hls_engine
// Supervision state and the single-pass step logic: watchdog, link state
// machine, enable handshake and captured device identity. The result of the
// beat in process is produced combinationally; state commits on fire.
// ============================================================================
module hls_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  hls_pkg::in_beat_t item,
    input  hls_pkg::cfg_t     cfg,
    output hls_pkg::out_beat_t res
);

    typedef enum logic [1:0] {
        LINK_INIT    = 2'd0,
        LINK_ONLINE  = 2'd1,
        LINK_OFFLINE = 2'd2
    } link_state_t;

    typedef enum logic [1:0] {
        HS_INIT     = 2'd0,
        HS_CONFIRM  = 2'd1,
        HS_ENABLED  = 2'd2,
        HS_DISABLED = 2'd3
    } hs_state_t;

    logic [7:0]  watchdog_reg, watchdog_next;
    logic        online_reg, online_next;
    link_state_t link_reg, link_next;
    hs_state_t   hs_reg, hs_next;
    logic [3:0]  wait_reg, wait_next;
    logic        enabled_reg, enabled_next;
    logic        remote_en_reg, remote_en_next;
    logic [7:0]  dev_type_reg, dev_type_next;
    logic [7:0]  dev_number_reg, dev_number_next;
    logic [1:0]  link_ev;
    logic [1:0]  en_ev;
    logic        send;

    // Next state and events for one beat.
    always_comb
    begin
        watchdog_next   = watchdog_reg;
        online_next     = online_reg;
        link_next       = link_reg;
        hs_next         = hs_reg;
        wait_next       = wait_reg;
        enabled_next    = enabled_reg;
        remote_en_next  = remote_en_reg;
        dev_type_next   = dev_type_reg;
        dev_number_next = dev_number_reg;
        link_ev         = hls_pkg::LINK_EV_NONE;
        en_ev           = hls_pkg::EN_EV_NONE;
        send            = 1'b0;

        if (item.cmd == hls_pkg::CMD_FRAME)
        begin
            // A frame of our class captures identity; a heartbeat refreshes the link.
            if (item.frame_class == cfg.device_class)
            begin
                dev_type_next   = item.frame_type;
                dev_number_next = item.frame_number;
                if (item.frame_function == hls_pkg::HEARTBEAT_FUNCTION)
                begin
                    remote_en_next = (item.frame_byte0 != 8'd0);
                    watchdog_next  = cfg.heartbeat_reload;
                    online_next    = 1'b1;
                end
            end
        end
        else
        begin
            // Watchdog: expire at zero, otherwise count down.
            if (watchdog_reg == 8'd0)
            begin
                online_next = 1'b0;
            end
            else
            begin
                watchdog_next = watchdog_reg - 8'd1;
            end

            // Link state machine.
            unique case (link_reg)
                LINK_ONLINE:
                begin
                    if (!online_next)
                    begin
                        link_next = LINK_OFFLINE;
                        link_ev   = hls_pkg::LINK_EV_OFFLINE;
                    end
                end
                LINK_OFFLINE:
                begin
                    if (online_next)
                    begin
                        link_next = LINK_ONLINE;
                        link_ev   = hls_pkg::LINK_EV_ONLINE;
                    end
                end
                default:
                begin
                    if (online_next)
                    begin
                        link_next = LINK_ONLINE;
                        link_ev   = hls_pkg::LINK_EV_ONLINE;
                    end
                    else if (watchdog_next == 8'd1)
                    begin
                        link_next = LINK_OFFLINE;
                        link_ev   = hls_pkg::LINK_EV_OFFLINE;
                    end
                end
            endcase

            // Enable handshake, paused while the link is down.
            if (online_next)
            begin
                if (wait_reg < cfg.retry_wait)
                begin
                    wait_next = wait_reg + 4'd1;
                end
                else
                begin
                    unique case (hs_reg)
                        HS_INIT:
                        begin
                            send      = 1'b1;
                            wait_next = 4'd0;
                            hs_next   = HS_CONFIRM;
                        end
                        HS_CONFIRM:
                        begin
                            if (remote_en_reg)
                            begin
                                hs_next      = HS_ENABLED;
                                enabled_next = 1'b1;
                                en_ev        = hls_pkg::EN_EV_ENABLED;
                            end
                            else
                            begin
                                hs_next      = HS_DISABLED;
                                enabled_next = 1'b0;
                                en_ev        = hls_pkg::EN_EV_DISABLED;
                            end
                        end
                        HS_ENABLED:
                        begin
                            if (!remote_en_reg)
                            begin
                                hs_next      = HS_DISABLED;
                                enabled_next = 1'b0;
                                en_ev        = hls_pkg::EN_EV_DISABLED;
                            end
                        end
                        default:
                        begin
                            if (remote_en_reg)
                            begin
                                hs_next      = HS_ENABLED;
                                enabled_next = 1'b1;
                                en_ev        = hls_pkg::EN_EV_ENABLED;
                            end
                            else
                            begin
                                send      = 1'b1;
                                wait_next = 4'd0;
                            end
                        end
                    endcase
                end
            end
        end
    end

    // Result of the beat in process.
    always_comb
    begin
        res.link_online    = online_next;
        res.device_enabled = enabled_next;
        res.link_event     = link_ev;
        res.enable_event   = en_ev;
        res.send_enable    = send;
        res.target_type    = dev_type_next;
        res.target_number  = dev_number_next;
    end

    // State commits when the beat moves to the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            watchdog_reg   <= hls_pkg::RESET_HEARTBEAT_RELOAD;
            online_reg     <= 1'b0;
            link_reg       <= LINK_INIT;
            hs_reg         <= HS_INIT;
            wait_reg       <= hls_pkg::RESET_RETRY_WAIT;
            enabled_reg    <= 1'b0;
            remote_en_reg  <= 1'b0;
            dev_type_reg   <= 8'd0;
            dev_number_reg <= 8'd0;
        end
        else if (fire)
        begin
            watchdog_reg   <= watchdog_next;
            online_reg     <= online_next;
            link_reg       <= link_next;
            hs_reg         <= hs_next;
            wait_reg       <= wait_next;
            enabled_reg    <= enabled_next;
            remote_en_reg  <= remote_en_next;
            dev_type_reg   <= dev_type_next;
            dev_number_reg <= dev_number_next;
        end
    end

`ifndef SYNTHESIS
    // An enable request restarts the retry wait.
    a_send_clears_wait: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.send_enable |=> wait_reg == 4'd0)
        else $error("enable request did not clear the retry wait");

    // A frame beat never raises events or requests.
    a_frame_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.cmd == hls_pkg::CMD_FRAME |->
        res.link_event == hls_pkg::LINK_EV_NONE &&
        res.enable_event == hls_pkg::EN_EV_NONE && !res.send_enable)
        else $error("frame beat produced an event");

    // A came-online event comes with the online flag set.
    a_online_event_flag: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.link_event == hls_pkg::LINK_EV_ONLINE |-> res.link_online)
        else $error("online event without online flag");

    // An enabled event comes with the enabled flag set, and the link up.
    a_enabled_event_flag: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.enable_event == hls_pkg::EN_EV_ENABLED |->
        res.device_enabled && res.link_online)
        else $error("enabled event without enabled flag");
`endif

endmodule

// ----- dv/hls_scoreboard_pkg.sv -----
// ============================================================================
// Heartbeat link supervisor scoreboard
// Tracks the supervisor's watchdog, link machine and enable handshake for
// every accepted input beat, queues the expected result beats and compares
// each returned result beat with the oldest expectation.
// ============================================================================
package hls_scoreboard_pkg;

    typedef enum logic [1:0] {
        LINK_INIT,
        LINK_UP,
        LINK_DOWN,
        LINK_SPARE
    } link_state_t;

    typedef enum logic [1:0] {
        HS_INIT,
        HS_CONFIRM,
        HS_ENABLED,
        HS_DISABLED
    } handshake_t;

    class supervisor_scoreboard;

        // Shadow copies of the configuration registers.
        logic [7:0]  reload_reg;
        logic [3:0]  retry_reg;
        logic [7:0]  class_reg;

        // Shadow copy of the supervisor state.
        logic [7:0]  watchdog;
        logic        online;
        link_state_t link_st;
        handshake_t  hs_st;
        logic [3:0]  retry_count;
        logic        enabled;
        logic        remote_on;
        logic [7:0]  dev_type;
        logic [7:0]  dev_number;

        // Result beats still owed by the block, oldest first.
        hls_pkg::out_beat_t expected_beats[$];

        int unsigned mismatches;
        int unsigned beats_noted;
        int unsigned results_seen;
        int unsigned link_events;
        int unsigned enable_events;
        int unsigned enable_requests;

        function new();
            reload_reg      = hls_pkg::RESET_HEARTBEAT_RELOAD;
            retry_reg       = hls_pkg::RESET_RETRY_WAIT;
            class_reg       = hls_pkg::RESET_DEVICE_CLASS;
            watchdog        = hls_pkg::RESET_HEARTBEAT_RELOAD;
            online          = 1'b0;
            link_st         = LINK_INIT;
            hs_st           = HS_INIT;
            retry_count     = hls_pkg::RESET_RETRY_WAIT;
            enabled         = 1'b0;
            remote_on       = 1'b0;
            dev_type        = 8'd0;
            dev_number      = 8'd0;
            mismatches      = 0;
            beats_noted     = 0;
            results_seen    = 0;
            link_events     = 0;
            enable_events   = 0;
            enable_requests = 0;
        endfunction

        // A write to an index with no register behind it changes nothing.
        function void write_register(logic [hls_pkg::CFG_INDEX_W-1:0] index,
                                     logic [hls_pkg::CFG_DATA_W-1:0] value);
            case (index)
                hls_pkg::REG_HEARTBEAT_RELOAD: reload_reg = value;
                hls_pkg::REG_RETRY_WAIT:       retry_reg  = value[3:0];
                hls_pkg::REG_DEVICE_CLASS:     class_reg  = value;
                default:                       ;
            endcase
        endfunction

        // Watchdog countdown, then the link machine. Returns the link event.
        function logic [1:0] step_link();
            logic [1:0] ev;
            ev = hls_pkg::LINK_EV_NONE;
            if (watchdog == 8'd0)
                online = 1'b0;
            else
                watchdog = watchdog - 8'd1;

            case (link_st)
                LINK_UP:
                begin
                    if (!online)
                    begin
                        link_st = LINK_DOWN;
                        ev      = hls_pkg::LINK_EV_OFFLINE;
                    end
                end
                LINK_DOWN:
                begin
                    if (online)
                    begin
                        link_st = LINK_UP;
                        ev      = hls_pkg::LINK_EV_ONLINE;
                    end
                end
                default:
                begin
                    // Leaving init: an expiring count goes offline, but an
                    // online link wins over it.
                    if (watchdog == 8'd1)
                    begin
                        link_st = LINK_DOWN;
                        ev      = hls_pkg::LINK_EV_OFFLINE;
                    end
                    if (online)
                    begin
                        link_st = LINK_UP;
                        ev      = hls_pkg::LINK_EV_ONLINE;
                    end
                end
            endcase
            return ev;
        endfunction

        // Enable handshake; it is frozen while the link is offline.
        function void step_handshake(output logic [1:0] ev, output logic send);
            ev   = hls_pkg::EN_EV_NONE;
            send = 1'b0;
            if (!online)
                return;
            if (retry_count < retry_reg)
            begin
                retry_count = retry_count + 4'd1;
                return;
            end

            case (hs_st)
                HS_INIT:
                begin
                    send        = 1'b1;
                    retry_count = 4'd0;
                    hs_st       = HS_CONFIRM;
                end
                HS_CONFIRM:
                begin
                    if (remote_on)
                    begin
                        hs_st   = HS_ENABLED;
                        enabled = 1'b1;
                        ev      = hls_pkg::EN_EV_ENABLED;
                    end
                    else
                    begin
                        hs_st   = HS_DISABLED;
                        enabled = 1'b0;
                        ev      = hls_pkg::EN_EV_DISABLED;
                    end
                end
                HS_ENABLED:
                begin
                    if (!remote_on)
                    begin
                        hs_st   = HS_DISABLED;
                        enabled = 1'b0;
                        ev      = hls_pkg::EN_EV_DISABLED;
                    end
                end
                default:
                begin
                    // Disabled: confirm the remote or ask again.
                    if (remote_on)
                    begin
                        hs_st   = HS_ENABLED;
                        enabled = 1'b1;
                        ev      = hls_pkg::EN_EV_ENABLED;
                    end
                    else
                    begin
                        send        = 1'b1;
                        retry_count = 4'd0;
                    end
                end
            endcase
        endfunction

        // Advance the shadow state by one accepted input beat and queue the
        // result beat that it must produce.
        function void note_input(hls_pkg::in_beat_t beat);
            hls_pkg::out_beat_t want;
            want = '0;
            beats_noted++;
            if (beat.cmd == hls_pkg::CMD_FRAME)
            begin
                if (beat.frame_class == class_reg)
                begin
                    dev_type   = beat.frame_type;
                    dev_number = beat.frame_number;
                    if (beat.frame_function == hls_pkg::HEARTBEAT_FUNCTION)
                    begin
                        remote_on = (beat.frame_byte0 != 8'd0);
                        watchdog  = reload_reg;
                        online    = 1'b1;
                    end
                end
            end
            else
            begin
                want.link_event = step_link();
                step_handshake(want.enable_event, want.send_enable);
            end
            want.link_online    = online;
            want.device_enabled = enabled;
            want.target_type    = dev_type;
            want.target_number  = dev_number;
            expected_beats.push_back(want);
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                mismatches++;
            end
        endfunction

        // Compare a returned result beat with the oldest expectation.
        function void check_result(hls_pkg::out_beat_t got);
            hls_pkg::out_beat_t want;
            results_seen++;
            if (expected_beats.size() == 0)
            begin
                $error("result beat %h arrived with nothing expected", got);
                mismatches++;
                return;
            end
            want = expected_beats.pop_front();
            compare_field("link_online",    8'(want.link_online),    8'(got.link_online));
            compare_field("device_enabled", 8'(want.device_enabled), 8'(got.device_enabled));
            compare_field("link_event",     8'(want.link_event),     8'(got.link_event));
            compare_field("enable_event",   8'(want.enable_event),   8'(got.enable_event));
            compare_field("send_enable",    8'(want.send_enable),    8'(got.send_enable));
            compare_field("target_type",    want.target_type,        got.target_type);
            compare_field("target_number",  want.target_number,      got.target_number);
            if (want.link_event != hls_pkg::LINK_EV_NONE)
                link_events++;
            if (want.enable_event != hls_pkg::EN_EV_NONE)
                enable_events++;
            if (want.send_enable)
                enable_requests++;
        endfunction

    endclass

endpackage

// ----- dv/heartbeat_link_supervisor_test.sv -----
// ============================================================================
// Heartbeat link supervisor testbench
// Drives ticks and frames into the supervisor under random idling on both
// channels, runs through a set of register settings including the extremes,
// and checks every result beat against a scoreboard that tracks the
// watchdog, the link machine and the enable handshake.
// ============================================================================
module heartbeat_link_supervisor_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD       = 8;
    localparam int RESET_CYCLES     = 5;
    localparam int DRAIN_CYCLES     = 8;
    localparam int LONG_HOLD_CYCLES = 64;
    localparam int POWER_UP_TICKS   = 200;
    localparam int PHASE_ITEMS      = 170;
    localparam int PHASE_COUNT      = 7;
    localparam int TIMEOUT_NS       = 8_000_000;

    // Index with no register behind it; writes there must be ignored.
    localparam logic [hls_pkg::CFG_INDEX_W-1:0] REG_SPARE_INDEX = 2'd3;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    hls_pkg::in_beat_t               in_data   = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    hls_pkg::out_beat_t              out_data;
    logic                            cfg_we    = 1'b0;
    logic [hls_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [hls_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;

    logic                            long_hold_req = 1'b0;
    int unsigned                     settings_used = 1;

    hls_scoreboard_pkg::supervisor_scoreboard sb = new();

    heartbeat_link_supervisor uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Hard limit on the run.
    initial
    begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

    // Mostly short pauses, now and then a long one.
    function automatic int unsigned pause_length();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(1, 2);
        if (pick < 95)
            return $urandom_range(3, 8);
        return $urandom_range(20, 40);
    endfunction

    function automatic int unsigned sender_gap();
        return ($urandom_range(0, 2) == 0) ? pause_length() : 0;
    endfunction

    // Fully random beat; also used as background payload for ticks.
    function automatic hls_pkg::in_beat_t random_beat();
        hls_pkg::in_beat_t beat;
        beat.cmd            = 1'($urandom_range(0, 1));
        beat.frame_class    = 8'($urandom_range(0, 255));
        beat.frame_type     = 8'($urandom_range(0, 255));
        beat.frame_number   = 8'($urandom_range(0, 255));
        beat.frame_function = 8'($urandom_range(0, 255));
        beat.frame_byte0    = 8'($urandom_range(0, 255));
        return beat;
    endfunction

    function automatic hls_pkg::in_beat_t tick_beat();
        hls_pkg::in_beat_t beat;
        beat     = random_beat();
        beat.cmd = hls_pkg::CMD_TICK;
        return beat;
    endfunction

    function automatic hls_pkg::in_beat_t frame_beat(logic [7:0] cls, logic [7:0] typ,
                                                     logic [7:0] num, logic [7:0] func,
                                                     logic [7:0] byte0);
        hls_pkg::in_beat_t beat;
        beat.cmd            = hls_pkg::CMD_FRAME;
        beat.frame_class    = cls;
        beat.frame_type     = typ;
        beat.frame_number   = num;
        beat.frame_function = func;
        beat.frame_byte0    = byte0;
        return beat;
    endfunction

    // Scoreboard hooks: both channels are sampled at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_input(in_data);
            if (out_valid && out_ready)
                sb.check_result(out_data);
        end
    end

    // Result receiver: random stalls in stretches, plus one long hold-off
    // on request so that the block backs up into its input.
    initial
    begin
        int unsigned gap_left;
        int unsigned mode_left;
        logic        stalls_on;
        gap_left  = 0;
        mode_left = 0;
        stalls_on = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                stalls_on = ($urandom_range(0, 3) != 0);
                mode_left = $urandom_range(50, 300);
            end
            else
                mode_left--;

            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
            end
            else if (gap_left != 0)
            begin
                out_ready <= 1'b0;
                gap_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (stalls_on && $urandom_range(0, 3) == 0)
                    gap_left = pause_length();
            end
        end
    end

    // Offer one input beat and hold it until accepted; with a nonzero gap, then drop in_valid and idle.
    task automatic send_beat(input hls_pkg::in_beat_t beat, input int unsigned gap);
        @(negedge clk);
        in_data  <= beat;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (gap != 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Stop offering beats and wait until every owed result has come back.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [hls_pkg::CFG_INDEX_W-1:0] index,
                             input logic [hls_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.write_register(index, value);
    endtask

    // Load all three registers; the unused upper bits of the retry write
    // carry noise that the block must drop.
    task automatic load_registers(input logic [7:0] reload, input logic [3:0] retry,
                                  input logic [7:0] cls);
        write_reg(hls_pkg::REG_HEARTBEAT_RELOAD, reload);
        write_reg(hls_pkg::REG_RETRY_WAIT, {4'($urandom_range(0, 15)), retry});
        write_reg(hls_pkg::REG_DEVICE_CLASS, cls);
        settings_used++;
    endtask

    // Random traffic: mostly ticks and heartbeats of our class, with silent
    // stretches long enough to let the watchdog expire, and some noise.
    task automatic run_random(input int unsigned target, input logic with_hold);
        int unsigned       counted;
        int unsigned       quiet;
        int unsigned       pick;
        int unsigned       burst_left;
        int unsigned       hold_burst;
        logic              gaps_on;
        hls_pkg::in_beat_t beat;
        counted    = 0;
        quiet      = 0;
        burst_left = 0;
        hold_burst = 0;
        gaps_on    = 1'b1;
        while (counted < target)
        begin
            if (burst_left == 0)
            begin
                gaps_on    = ($urandom_range(0, 2) != 0);
                burst_left = $urandom_range(20, 120);
            end
            else
                burst_left--;

            if (with_hold && counted == 30 && hold_burst == 0)
            begin
                long_hold_req = 1'b1;
                hold_burst    = 100;
            end

            beat = random_beat();
            pick = $urandom_range(0, 99);
            if (quiet != 0)
            begin
                quiet--;
                if (pick < 90)
                    beat.cmd = hls_pkg::CMD_TICK;
            end
            else if (pick < 2)
            begin
                quiet    = $urandom_range(1, int'(sb.reload_reg) + 4);
                beat.cmd = hls_pkg::CMD_TICK;
            end
            else if (pick < 55)
                beat.cmd = hls_pkg::CMD_TICK;
            else if (pick < 82)
            begin
                beat.cmd            = hls_pkg::CMD_FRAME;
                beat.frame_class    = sb.class_reg;
                beat.frame_function = hls_pkg::HEARTBEAT_FUNCTION;
                if ($urandom_range(0, 1) == 0)
                    beat.frame_byte0 = 8'd0;
            end
            else if (pick < 90)
            begin
                beat.cmd         = hls_pkg::CMD_FRAME;
                beat.frame_class = sb.class_reg;
            end

            if (beat.cmd == hls_pkg::CMD_TICK || beat.frame_class == sb.class_reg)
                counted++;

            if (hold_burst > 1)
            begin
                hold_burst--;
                send_beat(beat, 0);
            end
            else
                send_beat(beat, gaps_on ? sender_gap() : 0);
        end
    endtask

    // Main sequence.
    initial
    begin
        int unsigned phase;
        int unsigned k;
        logic [7:0]  reload_val;
        logic [3:0]  retry_val;
        logic [7:0]  class_val;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Power-up with reset settings and no heartbeat: the count walks
        // down until it reaches one and the link leaves init as offline.
        for (k = 0; k < POWER_UP_TICKS; k++)
            send_beat(tick_beat(), 0);
        wait_idle();

        // Directed part with a tiny reload, no retry wait and the top class.
        load_registers(8'd3, 4'd0, 8'hFF);
        write_reg(REG_SPARE_INDEX, 8'hFF);
        send_beat(tick_beat(), sender_gap());
        // Heartbeat of a foreign class is ignored.
        send_beat(frame_beat(8'h00, 8'h12, 8'h34, hls_pkg::HEARTBEAT_FUNCTION, 8'h01),
                  sender_gap());
        // Non-heartbeat frame of our class only captures the address.
        send_beat(frame_beat(8'hFF, 8'h00, 8'h00, 8'h00, 8'h00), sender_gap());
        // Heartbeat with remote disabled brings the link up.
        send_beat(frame_beat(8'hFF, 8'hFF, 8'hFF, hls_pkg::HEARTBEAT_FUNCTION, 8'h00),
                  sender_gap());
        // Online, first enable request, confirm fails, request again, expire.
        for (k = 0; k < 4; k++)
            send_beat(tick_beat(), sender_gap());
        // Remote now enabled: link returns and the handshake confirms.
        send_beat(frame_beat(8'hFF, 8'h01, 8'h80, hls_pkg::HEARTBEAT_FUNCTION, 8'h01),
                  sender_gap());
        send_beat(tick_beat(), sender_gap());
        // Remote drops its enable, then raises it again.
        send_beat(frame_beat(8'hFF, 8'hFE, 8'h7F, hls_pkg::HEARTBEAT_FUNCTION, 8'h00),
                  sender_gap());
        send_beat(tick_beat(), sender_gap());
        send_beat(frame_beat(8'hFF, 8'h55, 8'hAA, hls_pkg::HEARTBEAT_FUNCTION, 8'h80),
                  sender_gap());
        send_beat(tick_beat(), sender_gap());
        send_beat(frame_beat(8'hFF, 8'h5A, 8'hA5, 8'hB1, 8'hFF), sender_gap());
        // Let the watchdog run out and idle offline.
        for (k = 0; k < 5; k++)
            send_beat(tick_beat(), sender_gap());
        wait_idle();

        // Random phases over a range of settings, extremes first.
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            reload_val = 8'($urandom_range(2, 255));
            retry_val  = 4'($urandom_range(0, 15));
            class_val  = 8'($urandom_range(0, 255));
            case (phase)
                0:
                begin
                    reload_val = 8'd2;
                    retry_val  = 4'd15;
                    class_val  = 8'h00;
                end
                1:
                begin
                    reload_val = 8'd255;
                    retry_val  = 4'd15;
                    class_val  = hls_pkg::RESET_DEVICE_CLASS;
                end
                2:
                begin
                    // A zero reload expires on the very next tick.
                    reload_val = 8'd0;
                    retry_val  = 4'd3;
                    class_val  = 8'hA5;
                end
                3:
                begin
                    reload_val = 8'd1;
                    retry_val  = 4'd1;
                    class_val  = 8'h5A;
                end
                6:
                begin
                    reload_val = hls_pkg::RESET_HEARTBEAT_RELOAD;
                    retry_val  = hls_pkg::RESET_RETRY_WAIT;
                    class_val  = hls_pkg::RESET_DEVICE_CLASS;
                end
                default: ;
            endcase
            load_registers(reload_val, retry_val, class_val);
            run_random(PHASE_ITEMS, phase == 1);
            wait_idle();
        end

        $display("Run covered %0d input beats over %0d register settings; %0d results checked.",
                 sb.beats_noted, settings_used, sb.results_seen);
        $display("Seen: %0d link events, %0d enable events, %0d enable requests.",
                 sb.link_events, sb.enable_events, sb.enable_requests);
        if (sb.mismatches == 0 && sb.expected_beats.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
